// ===== hdl/spcr_pkg.sv =====
`timescale 1ns / 1ps
// Package for the sphere pair collision response block.
// Holds the fixed constants used by the front end, divider, back end and top level. No dependencies.
package spcr_pkg;

  // Number of spatial axes in a packed vector.
  localparam int unsigned NUM_AXES = 3;
  // Division lanes: three axes for sphere A, then three for sphere B.
  localparam int unsigned NUM_LANES = 2 * NUM_AXES;
  // Extra quotient bits above the component width. The correction term is at most
  // twice the velocity magnitude, plus one for rounding.
  localparam int unsigned QUOT_EXTRA = 2;

endpackage

// ===== hdl/spcr_ifs.sv =====
`timescale 1ns / 1ps
// Channel interfaces of the sphere pair collision response block.
// Depends on nothing; parameterised by the component width.
interface spcr_pair_if #(parameter int unsigned COMPONENT_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic [3*COMPONENT_WIDTH-1:0]   pos_a;
  logic [3*COMPONENT_WIDTH-1:0]   vel_a;
  logic [COMPONENT_WIDTH-2:0]     radius_a;
  logic [3*COMPONENT_WIDTH-1:0]   pos_b;
  logic [3*COMPONENT_WIDTH-1:0]   vel_b;
  logic [COMPONENT_WIDTH-2:0]     radius_b;
  modport source (output valid, pos_a, vel_a, radius_a, pos_b, vel_b, radius_b, input ready);
  modport sink   (input valid, pos_a, vel_a, radius_a, pos_b, vel_b, radius_b, output ready);
endinterface

interface spcr_resp_if #(parameter int unsigned COMPONENT_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic [3*COMPONENT_WIDTH-1:0]   new_vel_a;
  logic [3*COMPONENT_WIDTH-1:0]   new_vel_b;
  logic                           collided;
  modport source (output valid, new_vel_a, new_vel_b, collided, input ready);
  modport sink   (input valid, new_vel_a, new_vel_b, collided, output ready);
endinterface

// ===== hdl/spcr_front.sv =====
`timescale 1ns / 1ps
// Front end: four register stages computing displacement, dot products, the
// collision test and the division numerators. Depends on spcr_pkg.
module spcr_front
  import spcr_pkg::*;
#(
  parameter int unsigned C = 16
) (
  input  logic                   clk_i,
  input  logic [3:0]             en_i,
  input  logic [3*C-1:0]         pos_a_i,
  input  logic [3*C-1:0]         vel_a_i,
  input  logic [C-2:0]           radius_a_i,
  input  logic [3*C-1:0]         pos_b_i,
  input  logic [3*C-1:0]         vel_b_i,
  input  logic [C-2:0]           radius_b_i,
  output logic [3*C+6:0]         num_o [NUM_LANES],
  output logic [2*C+4:0]         den_o,
  output logic [NUM_LANES-1:0]   neg_o,
  output logic [3*C-1:0]         vel_a_o,
  output logic [3*C-1:0]         vel_b_o,
  output logic                   hit_o
);
  localparam int unsigned PW = 2 * C + 4;
  localparam int unsigned NW = 3 * C + 7;

  // Stage 1
  logic signed [C:0]     d1_d [NUM_AXES], d1_q [NUM_AXES];
  logic signed [C:0]     dv1_d [NUM_AXES], dv1_q [NUM_AXES];
  logic [C-1:0]          rs1_d, rs1_q;
  logic [3*C-1:0]        va1_q, vb1_q;
  // Stage 2
  logic signed [2*C+1:0] dd2_d [NUM_AXES], dd2_q [NUM_AXES];
  logic signed [2*C+1:0] rl2_d [NUM_AXES], rl2_q [NUM_AXES];
  logic signed [2*C+1:0] sa2_d [NUM_AXES], sa2_q [NUM_AXES];
  logic signed [2*C+1:0] sb2_d [NUM_AXES], sb2_q [NUM_AXES];
  logic [2*C-1:0]        rs2_d, rs2_q;
  logic signed [C:0]     d2_q [NUM_AXES];
  logic [3*C-1:0]        va2_q, vb2_q;
  // Stage 3
  logic signed [PW-1:0]  dd3_d, dd3_q, rl3_d, sa3_d, sa3_q, sb3_d, sb3_q;
  logic                  hit3_d, hit3_q;
  logic signed [C:0]     d3_q [NUM_AXES];
  logic [3*C-1:0]        va3_q, vb3_q;
  // Stage 4
  logic [NW-1:0]         num4_d [NUM_LANES], num4_q [NUM_LANES];
  logic [NUM_LANES-1:0]  neg4_d, neg4_q;
  logic [PW:0]           den4_q;
  logic [3*C-1:0]        va4_q, vb4_q;
  logic                  hit4_q;

  logic [C:0]            am [NUM_AXES];
  logic [PW-1:0]         sma, smb;
  logic signed [C-1:0]   pa, pb, va, vb;

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      pa = pos_a_i[k*C +: C];
      pb = pos_b_i[k*C +: C];
      va = vel_a_i[k*C +: C];
      vb = vel_b_i[k*C +: C];
      d1_d[k]  = (C+1)'(pa) - (C+1)'(pb);
      dv1_d[k] = (C+1)'(va) - (C+1)'(vb);
    end
    rs1_d = {1'b0, radius_a_i} + {1'b0, radius_b_i};
  end

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      dd2_d[k] = (2*C+2)'(d1_q[k]) * (2*C+2)'(d1_q[k]);
      rl2_d[k] = (2*C+2)'(dv1_q[k]) * (2*C+2)'(d1_q[k]);
      sa2_d[k] = (2*C+2)'($signed(va1_q[k*C +: C])) * (2*C+2)'(d1_q[k]);
      sb2_d[k] = (2*C+2)'($signed(vb1_q[k*C +: C])) * (2*C+2)'(d1_q[k]);
    end
    rs2_d = (2*C)'(rs1_q) * (2*C)'(rs1_q);
  end

  always_comb begin
    dd3_d = PW'(dd2_q[0]) + PW'(dd2_q[1]) + PW'(dd2_q[2]);
    rl3_d = PW'(rl2_q[0]) + PW'(rl2_q[1]) + PW'(rl2_q[2]);
    sa3_d = PW'(sa2_q[0]) + PW'(sa2_q[1]) + PW'(sa2_q[2]);
    sb3_d = PW'(sb2_q[0]) + PW'(sb2_q[1]) + PW'(sb2_q[2]);
    hit3_d = (dd3_d < $signed({4'b0000, rs2_q})) && (rl3_d < 0) && (dd3_d != 0);
  end

  always_comb begin
    sma = sa3_q[PW-1] ? PW'(-sa3_q) : PW'(sa3_q);
    smb = sb3_q[PW-1] ? PW'(-sb3_q) : PW'(sb3_q);
    for (int k = 0; k < NUM_AXES; k++) begin
      am[k] = d3_q[k][C] ? (C+1)'(-d3_q[k]) : (C+1)'(d3_q[k]);
      num4_d[k] = ((NW'(am[k]) * NW'(sma)) << 2) + NW'(unsigned'(dd3_q));
      num4_d[k+NUM_AXES] = ((NW'(am[k]) * NW'(smb)) << 2) + NW'(unsigned'(dd3_q));
      neg4_d[k] = d3_q[k][C] ^ sa3_q[PW-1];
      neg4_d[k+NUM_AXES] = d3_q[k][C] ^ sb3_q[PW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      d1_q <= d1_d; dv1_q <= dv1_d; rs1_q <= rs1_d;
      va1_q <= vel_a_i; vb1_q <= vel_b_i;
    end
    if (en_i[1]) begin
      dd2_q <= dd2_d; rl2_q <= rl2_d; sa2_q <= sa2_d; sb2_q <= sb2_d;
      rs2_q <= rs2_d; d2_q <= d1_q; va2_q <= va1_q; vb2_q <= vb1_q;
    end
    if (en_i[2]) begin
      dd3_q <= dd3_d; sa3_q <= sa3_d; sb3_q <= sb3_d; hit3_q <= hit3_d;
      d3_q <= d2_q; va3_q <= va2_q; vb3_q <= vb2_q;
    end
    if (en_i[3]) begin
      num4_q <= num4_d; neg4_q <= neg4_d;
      den4_q <= {unsigned'(dd3_q), 1'b0};
      va4_q <= va3_q; vb4_q <= vb3_q; hit4_q <= hit3_q;
    end
  end

  assign num_o   = num4_q;
  assign den_o   = den4_q;
  assign neg_o   = neg4_q;
  assign vel_a_o = va4_q;
  assign vel_b_o = vb4_q;
  assign hit_o   = hit4_q;
endmodule

// ===== hdl/spcr_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per register stage for six lanes
// sharing a divisor, with side data carried alongside. Depends on spcr_pkg.
module spcr_div
  import spcr_pkg::*;
#(
  parameter int unsigned NW   = 55,
  parameter int unsigned DW   = 37,
  parameter int unsigned QB   = 18,
  parameter int unsigned SW   = 103
) (
  input  logic           clk_i,
  input  logic [QB-1:0]  en_i,
  input  logic [NW-1:0]  num_i [NUM_LANES],
  input  logic [DW-1:0]  den_i,
  input  logic [SW-1:0]  side_i,
  output logic [QB-1:0]  quot_o [NUM_LANES],
  output logic [SW-1:0]  side_o
);
  logic [NW-1:0] rem_q  [QB][NUM_LANES];
  logic [QB-1:0] quo_q  [QB][NUM_LANES];
  logic [DW-1:0] den_q  [QB];
  logic [SW-1:0] side_q [QB];

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [NW-1:0] rem_in [NUM_LANES];
    logic [QB-1:0] quo_in [NUM_LANES];
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic [NW-1:0] rem_d  [NUM_LANES];
    logic [QB-1:0] quo_d  [NUM_LANES];
    logic [NW-1:0] trial;

    if (s == 0) begin : g_first
      always_comb begin
        for (int j = 0; j < NUM_LANES; j++) begin
          rem_in[j] = num_i[j];
          quo_in[j] = '0;
        end
      end
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    // Divisor aligned to the quotient bit this stage decides.
    assign trial = NW'(den_in) << (QB - 1 - s);

    always_comb begin
      for (int j = 0; j < NUM_LANES; j++) begin
        if (rem_in[j] >= trial) begin
          rem_d[j] = rem_in[j] - trial;
          quo_d[j] = {quo_in[j][QB-2:0], 1'b1};
        end else begin
          rem_d[j] = rem_in[j];
          quo_d[j] = {quo_in[j][QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s]  <= rem_d;
        quo_q[s]  <= quo_d;
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign quot_o = quo_q[QB-1];
  assign side_o = side_q[QB-1];
endmodule

// ===== hdl/spcr_back.sv =====
`timescale 1ns / 1ps
// Back end: applies the signed correction to colliding pairs (others keep their velocities),
// saturates and holds the result in the output register. Depends on spcr_pkg.
module spcr_back
  import spcr_pkg::*;
#(
  parameter int unsigned C  = 16,
  parameter int unsigned QB = 18
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [QB-1:0]         quot_i [NUM_LANES],
  input  logic [NUM_LANES-1:0]  neg_i,
  input  logic [3*C-1:0]        vel_a_i,
  input  logic [3*C-1:0]        vel_b_i,
  input  logic                  hit_i,
  output logic [3*C-1:0]        new_vel_a_o,
  output logic [3*C-1:0]        new_vel_b_o,
  output logic                  collided_o
);
  localparam int unsigned VW = QB + 2;
  localparam logic signed [VW-1:0] MaxV = VW'((2 ** (C - 1)) - 1);
  localparam logic signed [VW-1:0] MinV = -VW'(2 ** (C - 1));

  logic [6*C-1:0]        vin;
  logic [6*C-1:0]        vout;
  logic [3*C-1:0]        va_d, vb_d, va_q, vb_q;
  logic                  col_q;
  logic signed [VW-1:0]  delta, diff;
  logic signed [C-1:0]   sat;

  assign vin = {vel_b_i, vel_a_i};

  always_comb begin
    for (int j = 0; j < NUM_LANES; j++) begin
      delta = neg_i[j] ? -$signed(VW'(quot_i[j])) : $signed(VW'(quot_i[j]));
      diff  = VW'($signed(vin[j*C +: C])) - delta;
      if (diff > MaxV) begin
        sat = MaxV[C-1:0];
      end else if (diff < MinV) begin
        sat = MinV[C-1:0];
      end else begin
        sat = diff[C-1:0];
      end
      vout[j*C +: C] = sat;
    end
    va_d = hit_i ? vout[3*C-1:0] : vel_a_i;
    vb_d = hit_i ? vout[6*C-1:3*C] : vel_b_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      va_q  <= va_d;
      vb_q  <= vb_d;
      col_q <= hit_i;
    end
  end

  assign new_vel_a_o = va_q;
  assign new_vel_b_o = vb_q;
  assign collided_o  = col_q;
endmodule

// ===== hdl/sphere_pair_collision_response_top.sv =====
`timescale 1ns / 1ps
// Top level of the sphere pair collision response pipeline.
// Depends on spcr_pkg, spcr_ifs, spcr_front, spcr_div and spcr_back.
//
//  Channel  | Direction | Carries
//  ---------+-----------+------------------------------------------------------
//  pair_i   | in        | pos_a, vel_a, radius_a, pos_b, vel_b, radius_b
//  resp_o   | out       | new_vel_a, new_vel_b, collided
//
// One transaction may enter on every clock cycle unless a stalled output has filled the
// pipeline. The stages are four front-end stages (difference, products, sums and test,
// numerators), COMPONENT_WIDTH + 2 divider stages deciding one quotient bit each, and
// the output register. The divider pipeline sets the latency.
// Reset clears every stage valid bit; the data registers are not reset.
// Each stage holds only while it is full and the stage after it cannot take its
// contents, so bubbles close up and a stalled output never loses or repeats a
// transaction.
module sphere_pair_collision_response_top
  import spcr_pkg::*;
#(
  parameter int unsigned COMPONENT_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  spcr_pair_if.sink   pair_i,
  spcr_resp_if.source resp_o
);
  localparam int unsigned C  = COMPONENT_WIDTH;
  localparam int unsigned QB = C + QUOT_EXTRA;
  localparam int unsigned NW = 3 * C + 7;
  localparam int unsigned DW = 2 * C + 5;
  localparam int unsigned SW = 6 * C + NUM_LANES + 1;
  // Front end, divider, output register.
  localparam int unsigned NS = 4 + QB + 1;

  logic [NS-1:0] valid_d, valid_q;
  logic [NS-1:0] en;

  logic [NW-1:0]        num [NUM_LANES];
  logic [DW-1:0]        den;
  logic [NUM_LANES-1:0] neg_f, neg_b;
  logic [3*C-1:0]       va_f, vb_f, va_b, vb_b;
  logic                 hit_f, hit_b;
  logic [QB-1:0]        quot [NUM_LANES];
  logic [SW-1:0]        side_out;

  // A stage may load when it is empty or its contents move on this cycle.
  always_comb begin
    en[NS-1] = !valid_q[NS-1] || resp_o.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
  end

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      if (!en[i]) begin
        valid_d[i] = valid_q[i];
      end else if (i == 0) begin
        valid_d[i] = pair_i.valid;
      end else begin
        valid_d[i] = valid_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign pair_i.ready = en[0];
  assign resp_o.valid = valid_q[NS-1];

  spcr_front #(.C(C)) u_front (
    .clk_i      (clk_i),
    .en_i       (en[3:0]),
    .pos_a_i    (pair_i.pos_a),
    .vel_a_i    (pair_i.vel_a),
    .radius_a_i (pair_i.radius_a),
    .pos_b_i    (pair_i.pos_b),
    .vel_b_i    (pair_i.vel_b),
    .radius_b_i (pair_i.radius_b),
    .num_o      (num),
    .den_o      (den),
    .neg_o      (neg_f),
    .vel_a_o    (va_f),
    .vel_b_o    (vb_f),
    .hit_o      (hit_f)
  );

  spcr_div #(.NW(NW), .DW(DW), .QB(QB), .SW(SW)) u_div (
    .clk_i  (clk_i),
    .en_i   (en[4 +: QB]),
    .num_i  (num),
    .den_i  (den),
    .side_i ({hit_f, neg_f, vb_f, va_f}),
    .quot_o (quot),
    .side_o (side_out)
  );

  assign {hit_b, neg_b, vb_b, va_b} = side_out;

  spcr_back #(.C(C), .QB(QB)) u_back (
    .clk_i       (clk_i),
    .en_i        (en[NS-1]),
    .quot_i      (quot),
    .neg_i       (neg_b),
    .vel_a_i     (va_b),
    .vel_b_i     (vb_b),
    .hit_i       (hit_b),
    .new_vel_a_o (resp_o.new_vel_a),
    .new_vel_b_o (resp_o.new_vel_b),
    .collided_o  (resp_o.collided)
  );

  // An accepted transaction lands in the first stage.
  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_i.valid && pair_i.ready |=> valid_q[0])
    else $error("accepted transaction missing from first stage");

  // Input is refused only when the whole pipeline is full up to the output.
  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pair_i.ready |-> valid_q[NS-1] && !resp_o.ready && $countones(valid_q) == NS)
    else $error("input stalled while the pipeline had room");

  // The last front-end stage, when full and the first divider stage loads, hands its transaction on.
  a_stage_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[3] && en[4] |=> valid_q[4])
    else $error("transaction lost between front end and divider");
endmodule
